[src/gnlf_pkg.sv]
// gnlf_pkg: shared constants and controller/datapath handshake types
// for the gated newline line framer; no dependencies
package gnlf_pkg;

   typedef logic [7:0] byte_type;

   // item opcodes
   localparam logic OP_BYTE          = 1'b0;
   localparam logic OP_SESSION_RESET = 1'b1;

   // framing characters
   localparam byte_type CH_NEWLINE = 8'h0A;
   localparam byte_type CH_RETURN  = 8'h0D;

   // controller to datapath commands
   typedef struct packed {
      logic store_byte;    // write the byte at the current length, bump length
      logic clear_line;    // length to zero, discarding cleared
      logic set_discard;   // start skipping an overlong line
      logic start_replay;  // read index to zero
      logic next_rd;       // advance read index
      logic load_out;      // move store read data into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_session_reset;
      logic is_newline;
      logic is_return;
      logic authorized;
      logic len_zero;
      logic discarding;
      logic full;
      logic rd_last;
      logic out_free;
   } status_type;

endpackage

[src/gnlf_if.sv]
// gnlf_req_if / gnlf_rsp_if: valid/ready channel interfaces
// depends on gnlf_pkg for the byte type
interface gnlf_req_if;
   import gnlf_pkg::*;
   logic     valid;
   logic     ready;
   logic     op;
   byte_type data_byte;
   logic     authorized;
   modport source (output valid, output op, output data_byte, output authorized,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input authorized,
                   output ready);
endinterface

interface gnlf_rsp_if;
   import gnlf_pkg::*;
   logic     valid;
   logic     ready;
   byte_type line_byte;
   logic     last;
   modport source (output valid, output line_byte, output last, input ready);
   modport sink   (input valid, input line_byte, input last, output ready);
endinterface

[src/gnlf_ram.sv]
// gnlf_ram: generic single-write, single-read RAM with registered read
// no dependencies
module gnlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/gnlf_ctrl.sv]
// gnlf_ctrl: framer controller, accepts items and sequences line replay
// depends on gnlf_pkg for command and status types
module gnlf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gnlf_pkg::status_type status,
   output gnlf_pkg::cmd_type    cmd
);
   import gnlf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_session_reset) begin
                  cmd.clear_line = 1'b1;
               end else if (status.is_newline) begin
                  if (!status.len_zero && !status.discarding && status.authorized) begin
                     cmd.start_replay = 1'b1;
                     state_in         = ST_FETCH;
                  end else begin
                     cmd.clear_line = 1'b1;
                  end
               end else if (status.is_return || status.discarding) begin
                  cmd = '0;
               end else if (!status.full) begin
                  cmd.store_byte = 1'b1;
               end else begin
                  cmd.clear_line  = 1'b1;
                  cmd.set_discard = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.rd_last) begin
                  cmd.clear_line = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.next_rd = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/gnlf_dp.sv]
// gnlf_dp: framer datapath, line store, length, discard flag, output register
// depends on gnlf_pkg and gnlf_ram
module gnlf_dp #(
   parameter int LINE_MAX = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_op,
   input  gnlf_pkg::byte_type   req_data_byte,
   input  logic                 req_authorized,
   output gnlf_pkg::byte_type   rsp_line_byte,
   output logic                 rsp_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  gnlf_pkg::cmd_type    cmd,
   output gnlf_pkg::status_type status
);
   import gnlf_pkg::*;

   localparam int DEPTH = LINE_MAX - 1;
   localparam int LEN_W = $clog2(LINE_MAX);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [LEN_W-1:0] length_ff, length_in;
   logic             discarding_ff, discarding_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   byte_type         rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   byte_type         rd_data;

   gnlf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (length_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      status.is_session_reset = (req_op == OP_SESSION_RESET);
      status.is_newline       = (req_data_byte == CH_NEWLINE);
      status.is_return        = (req_data_byte == CH_RETURN);
      status.authorized       = req_authorized;
      status.len_zero         = (length_ff == '0);
      status.discarding       = discarding_ff;
      status.full             = (length_ff == LEN_W'(DEPTH));
      status.rd_last          = (LEN_W'(rd_idx_ff) == length_ff - LEN_W'(1));
      status.out_free         = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      length_in     = length_ff;
      discarding_in = discarding_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.store_byte) begin
         length_in = length_ff + LEN_W'(1);
      end
      if (cmd.clear_line) begin
         length_in     = '0;
         discarding_in = 1'b0;
      end
      if (cmd.set_discard) begin
         discarding_in = 1'b1;
      end
      if (cmd.start_replay) begin
         rd_idx_in = '0;
      end
      if (cmd.next_rd) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_data;
         rsp_last_in  = status.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         discarding_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         length_ff     <= length_in;
         discarding_ff <= discarding_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[src/gated_newline_line_framer_unit.sv]
// gated_newline_line_framer_unit: top level of the newline line framer
// depends on gnlf_pkg, gnlf_if, gnlf_ctrl, gnlf_dp (and gnlf_ram below it)
//
// usage
//   req channel: one item per transfer; op selects a received byte or a
//   session reset that drops the partial line; authorized gates delivery
//   rsp channel: the bytes of a completed line, in arrival order, with last
//   set on the final byte
//   carriage returns are ignored; a line longer than LINE_MAX-1 bytes is
//   dropped and input is skipped up to and including the next newline
//   sequencing: a byte, carriage return or session reset is handled in the
//   idle state as it is accepted; a deliverable newline starts a replay of
//   the line store in which each byte is first read from the store (fetch
//   state), then loaded into the output register (load state), and req
//   ready stays low until the replay ends
//   reset: line length and discarding flag clear, rsp valid drops; the line
//   store keeps stale contents, only entries written since are read
//   stall: a result waits in the output register while rsp ready is low;
//   the replay pauses behind it, and req stays blocked until the last byte
//   of the line is loaded into the output register
module gated_newline_line_framer_unit #(
   parameter int LINE_MAX = 64
) (
   input  logic       clock,
   input  logic       reset,
   gnlf_req_if.sink   req,
   gnlf_rsp_if.source rsp
);
   import gnlf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: item acceptance and replay sequencing
   gnlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: line store, length, discard flag, output register
   gnlf_dp #(
      .LINE_MAX (LINE_MAX)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req.op),
      .req_data_byte  (req.data_byte),
      .req_authorized (req.authorized),
      .rsp_line_byte  (rsp.line_byte),
      .rsp_last       (rsp.last),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
